// ----- src/hsm_pkg.sv -----
// Shared constants and controller/datapath interface types for the sliding median filter.
`timescale 1ns / 1ps
`default_nettype none

package hsm_pkg;

  localparam int BUCKETS   = 100;
  localparam int WINDOW    = 32;
  localparam int CHANNELS  = 2;
  localparam int MIN_HELD  = 4;
  localparam int RESET_OFFSET = 10;

  localparam int SMP_W     = 8;
  localparam int CH_W      = 1;
  localparam int BIN_W     = $clog2(BUCKETS);
  localparam int POS_W     = $clog2(WINDOW);
  localparam int CNT_W     = $clog2(WINDOW + 1);
  localparam int SUM_W     = CNT_W + 1;
  localparam int HIST_AW   = CH_W + BIN_W;
  localparam int RING_AW   = CH_W + POS_W;
  localparam int HIST_DEPTH = 2 ** HIST_AW;
  localparam int RING_DEPTH = 2 ** RING_AW;

  // Commands from the controller to the datapath, one step per bit.
  typedef struct packed {
    logic load;
    logic clr;
    logic ring_rd;
    logic old_rd;
    logic old_wr;
    logic new_rd;
    logic new_wr;
    logic scan_init;
    logic scan;
    logic finish;
  } cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic do_store;
    logic slot_full;
    logic enough;
    logic scan_done;
    logic clr_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ----- src/hsm_dp.sv -----
// Datapath of the sliding median filter: histogram and ring memories, counters, scan and output.
`timescale 1ns / 1ps
`default_nettype none

module hsm_dp (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_wr_en,
  input  wire logic [hsm_pkg::SMP_W-1:0] cfg_wr_data,
  input  wire logic [hsm_pkg::CH_W-1:0]  in_channel,
  input  wire logic [hsm_pkg::SMP_W-1:0] in_sample,
  input  wire hsm_pkg::cmd_t             cmd,
  output hsm_pkg::sts_t                  sts,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic [hsm_pkg::SMP_W-1:0]      out_median,
  output logic [hsm_pkg::CNT_W-1:0]      out_held
);

  localparam int SMP_W   = hsm_pkg::SMP_W;
  localparam int CH_W    = hsm_pkg::CH_W;
  localparam int BIN_W   = hsm_pkg::BIN_W;
  localparam int POS_W   = hsm_pkg::POS_W;
  localparam int CNT_W   = hsm_pkg::CNT_W;
  localparam int SUM_W   = hsm_pkg::SUM_W;
  localparam int HIST_AW = hsm_pkg::HIST_AW;
  localparam int RING_AW = hsm_pkg::RING_AW;

  logic [SMP_W-1:0]   offset_r;
  logic [CH_W-1:0]    ch_r;
  logic [BIN_W-1:0]   nb_r;
  logic               in_rng_r;
  logic               ch_ok_r;

  logic [POS_W-1:0]   pos_r   [hsm_pkg::CHANNELS];
  logic [CNT_W-1:0]   total_r [hsm_pkg::CHANNELS];
  logic [hsm_pkg::RING_DEPTH-1:0] slot_vld_r;

  logic [BIN_W-1:0]   ring_mem [hsm_pkg::RING_DEPTH];
  logic [BIN_W-1:0]   ring_q_r;
  logic [CNT_W-1:0]   hist_mem [hsm_pkg::HIST_DEPTH];
  logic [CNT_W-1:0]   hist_q_r;
  logic [HIST_AW-1:0] clr_addr_r;

  logic [BIN_W-1:0]   rd_bin_r;
  logic               q_vld_r;
  logic [BIN_W-1:0]   q_bin_r;
  logic [SUM_W-1:0]   run_r;
  logic [CNT_W-1:0]   target_r;
  logic [BIN_W-1:0]   res_bin_r;

  logic               out_valid_r;
  logic [SMP_W-1:0]   out_med_r;
  logic [CNT_W-1:0]   out_held_r;

  logic [RING_AW-1:0] ring_idx;
  logic [CNT_W-1:0]   cur_total;
  logic [SMP_W-1:0]   diff;
  logic [SUM_W-1:0]   sum;
  logic               hist_we;
  logic [HIST_AW-1:0] hist_wa;
  logic [CNT_W-1:0]   hist_wd;
  logic [HIST_AW-1:0] hist_ra;

  assign ring_idx  = {ch_r, pos_r[ch_r]};
  assign cur_total = total_r[ch_r];
  assign diff      = in_sample - offset_r;
  assign sum       = run_r + SUM_W'(hist_q_r);

  assign sts.do_store  = ch_ok_r && in_rng_r;
  assign sts.slot_full = slot_vld_r[ring_idx];
  assign sts.enough    = ch_ok_r && (cur_total >= CNT_W'(hsm_pkg::MIN_HELD));
  assign sts.scan_done = q_vld_r &&
                         ((sum >= SUM_W'(target_r)) || (q_bin_r == BIN_W'(hsm_pkg::BUCKETS - 1)));
  assign sts.clr_done  = (clr_addr_r == HIST_AW'(hsm_pkg::HIST_DEPTH - 1));
  assign sts.out_free  = !out_valid_r || out_tready;

  // Histogram port selection: clearing, removal of the overwritten sample, insertion.
  always_comb begin
    hist_we = 1'b0;
    hist_wa = clr_addr_r;
    hist_wd = '0;
    if (cmd.clr) begin
      hist_we = 1'b1;
    end else if (cmd.old_wr) begin
      hist_we = 1'b1;
      hist_wa = {ch_r, ring_q_r};
      hist_wd = (hist_q_r != '0) ? hist_q_r - CNT_W'(1) : '0;
    end else if (cmd.new_wr) begin
      hist_we = 1'b1;
      hist_wa = {ch_r, nb_r};
      hist_wd = hist_q_r + CNT_W'(1);
    end
  end

  always_comb begin
    priority if (cmd.old_rd) begin
      hist_ra = {ch_r, ring_q_r};
    end else if (cmd.new_rd) begin
      hist_ra = {ch_r, nb_r};
    end else begin
      hist_ra = {ch_r, rd_bin_r};
    end
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_wa] <= hist_wd;
    end
    hist_q_r <= hist_mem[hist_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.new_wr) begin
      ring_mem[ring_idx] <= nb_r;
    end
    if (cmd.ring_rd) begin
      ring_q_r <= ring_mem[ring_idx];
    end
  end

  // Item, scan and result payload.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ch_r     <= in_channel;
      ch_ok_r  <= int'(in_channel) < hsm_pkg::CHANNELS;
      in_rng_r <= (in_sample >= offset_r) &&
                  ({1'b0, diff} < (SMP_W + 1)'(hsm_pkg::BUCKETS));
      nb_r     <= BIN_W'(diff);
    end
    if (cmd.scan_init) begin
      run_r    <= '0;
      target_r <= cur_total >> 1;
    end
    if (cmd.scan) begin
      q_bin_r <= rd_bin_r;
      if (q_vld_r) begin
        run_r <= sum;
      end
      if (sts.scan_done) begin
        res_bin_r <= q_bin_r;
      end
    end
    if (cmd.finish) begin
      out_med_r  <= sts.enough ? SMP_W'(res_bin_r) + offset_r : '0;
      out_held_r <= ch_ok_r ? cur_total : '0;
    end
  end

  // Control state: offset, clear address, per-channel counters, slot valid bits, scan and output flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r    <= SMP_W'(hsm_pkg::RESET_OFFSET);
      slot_vld_r  <= '0;
      clr_addr_r  <= '0;
      rd_bin_r    <= '0;
      q_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < hsm_pkg::CHANNELS; i++) begin
        pos_r[i]   <= '0;
        total_r[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        offset_r <= cfg_wr_data;
      end
      if (cmd.clr) begin
        clr_addr_r <= clr_addr_r + HIST_AW'(1);
      end
      if (cmd.new_wr) begin
        slot_vld_r[ring_idx] <= 1'b1;
        pos_r[ch_r] <= (pos_r[ch_r] == POS_W'(hsm_pkg::WINDOW - 1)) ?
                       '0 : pos_r[ch_r] + POS_W'(1);
        if (!slot_vld_r[ring_idx]) begin
          total_r[ch_r] <= cur_total + CNT_W'(1);
        end
      end
      if (cmd.scan_init) begin
        rd_bin_r <= '0;
        q_vld_r  <= 1'b0;
      end else if (cmd.scan) begin
        q_vld_r <= 1'b1;
        if (rd_bin_r != BIN_W'(hsm_pkg::BUCKETS - 1)) begin
          rd_bin_r <= rd_bin_r + BIN_W'(1);
        end
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_median = out_med_r;
  assign out_held   = out_held_r;

  // A window never holds more samples than it has slots.
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ch_ok_r |-> cur_total <= CNT_W'(hsm_pkg::WINDOW))
    else $error("held count above window size");

  // The bucket of a sample still in the window is never empty when it is removed.
  a_old_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.old_wr |-> hist_q_r != '0)
    else $error("removing a sample from an empty bucket");

  // The slot just written is marked as holding a sample.
  a_slot_marked: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.new_wr |=> slot_vld_r[$past(ring_idx)])
    else $error("written slot not marked valid");

  // A result is only loaded into a free output register.
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || out_tready))
    else $error("result overwrote a pending transaction");

endmodule

`default_nettype wire

// ----- src/hsm_ctrl.sv -----
// Controller state machine that sequences histogram clearing, update, median scan and result hand-off.
`timescale 1ns / 1ps
`default_nettype none

module hsm_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire hsm_pkg::sts_t sts,
  output hsm_pkg::cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECIDE,
    S_RING_RD,
    S_OLD_RD,
    S_OLD_WR,
    S_NEW_RD,
    S_NEW_WR,
    S_PREP,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   in_ready_r;
  logic   in_ready_nxt;

  always_comb begin
    cmd          = '0;
    state_nxt    = state_r;
    in_ready_nxt = in_ready_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_done) begin
          state_nxt    = S_IDLE;
          in_ready_nxt = 1'b1;
        end
      end
      S_IDLE: begin
        if (in_tvalid && in_ready_r) begin
          cmd.load     = 1'b1;
          state_nxt    = S_DECIDE;
          in_ready_nxt = 1'b0;
        end
      end
      S_DECIDE: begin
        if (!sts.do_store) begin
          state_nxt = S_PREP;
        end else if (sts.slot_full) begin
          state_nxt = S_RING_RD;
        end else begin
          state_nxt = S_NEW_RD;
        end
      end
      S_RING_RD: begin
        cmd.ring_rd = 1'b1;
        state_nxt   = S_OLD_RD;
      end
      S_OLD_RD: begin
        cmd.old_rd = 1'b1;
        state_nxt  = S_OLD_WR;
      end
      S_OLD_WR: begin
        cmd.old_wr = 1'b1;
        state_nxt  = S_NEW_RD;
      end
      S_NEW_RD: begin
        cmd.new_rd = 1'b1;
        state_nxt  = S_NEW_WR;
      end
      S_NEW_WR: begin
        cmd.new_wr = 1'b1;
        state_nxt  = S_PREP;
      end
      S_PREP: begin
        cmd.scan_init = 1'b1;
        state_nxt     = sts.enough ? S_SCAN : S_FINISH;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.finish   = 1'b1;
          state_nxt    = S_IDLE;
          in_ready_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt    = S_IDLE;
        in_ready_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= in_ready_nxt;
    end
  end

  assign in_tready = in_ready_r;

endmodule

`default_nettype wire

// ----- src/histogram_sliding_median.sv -----
// Top level of the per-channel histogram sliding-window median filter.
// Each accepted transaction carries one 8-bit sample and its channel and yields exactly one
// result transaction with the window median and the number of samples held. One item is
// processed at a time. A decision state follows acceptance. A sample out of range skips the
// update; an in-range sample that replaces an older one passes the states ring read,
// old-bucket read, old-bucket write, new-bucket read and new-bucket write, and one that
// fills a fresh slot passes only new-bucket read and write. A preparation state follows.
// The median scan, run only when at least four samples are held, then walks the channel's
// histogram one bucket per cycle through the histogram memory read port. A last state
// loads the result register once it is free, and the result waits there while out_tready
// is low. After reset the block clears its 256-entry histogram memory in one pass and
// accepts no sample until it is done. The offset register is written whenever cfg_wr_en is
// high, so write it only while no transaction is in flight.
`timescale 1ns / 1ps
`default_nettype none

module histogram_sliding_median (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,  // range_offset
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,     // [7:0] sample
  input  wire logic [0:0]  in_tuser,     // [0] channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata     // [7:0] median_value, [13:8] held_count, [15:14] zero
);

  hsm_pkg::cmd_t cmd;
  hsm_pkg::sts_t sts;
  logic [hsm_pkg::SMP_W-1:0] median;
  logic [hsm_pkg::CNT_W-1:0] held;

  hsm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  hsm_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_channel  (in_tuser),
    .in_sample   (in_tdata),
    .cmd         (cmd),
    .sts         (sts),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_median  (median),
    .out_held    (held)
  );

  assign out_tdata = {2'b00, held, median};

endmodule

`default_nettype wire
